// ----- src/fdtw_pkg.sv -----
// Shared constants, types and helpers for the device-tree structure walker.
package fdtw_pkg;

  localparam int MAX_NAME_CHARS = 8;
  localparam int INDEX_BITS     = 24;
  localparam int DEPTH_BITS     = 8;
  localparam int POS_BITS       = 4;
  localparam int TLEN_BITS      = 4;
  localparam int SKIP_BITS      = 31;
  localparam int NAME_BITS      = 8 * MAX_NAME_CHARS;
  localparam int CHAR_SEL_BITS  = (MAX_NAME_CHARS > 1) ? $clog2(MAX_NAME_CHARS) : 1;

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
  localparam logic [POS_BITS-1:0]   POS_MAX   = '1;
  localparam logic [TLEN_BITS-1:0]  TLEN_MAX  = TLEN_BITS'(MAX_NAME_CHARS);

  // Structure block tokens
  localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TOK_END_NODE   = 32'd2;
  localparam logic [31:0] TOK_PROP       = 32'd3;
  localparam logic [31:0] TOK_END        = 32'd9;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_AT  = 8'h40;

  // Event kinds
  localparam logic [1:0] EV_BEGIN_NODE = 2'd0;
  localparam logic [1:0] EV_END_NODE   = 2'd1;
  localparam logic [1:0] EV_PROP       = 2'd2;
  localparam logic [1:0] EV_END        = 2'd3;

  // Configuration register indexes
  localparam logic CFG_TARGET_NAME   = 1'b0;
  localparam logic CFG_TARGET_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0]            event_kind;
    logic [INDEX_BITS-1:0] tok_index;
    logic [DEPTH_BITS-1:0] nesting_depth;
    logic [31:0]           value_length;
    logic [31:0]           string_offset;
    logic                  matched;
    logic                  walk_done;
  } event_t;

  typedef struct packed {
    logic                ended;
    logic [POS_BITS-1:0] position;
    logic                equal;
  } name_scan_t;

  // Target character p, first character in the top byte
  function automatic logic [7:0] target_char(input logic [NAME_BITS-1:0] name,
                                             input logic [CHAR_SEL_BITS-1:0] p);
    return name[NAME_BITS - 8 - 8 * p +: 8];
  endfunction

endpackage

// ----- src/fdtw_name_scan.sv -----
// Four-byte node-name scan: zero-byte search and target compare for one word.
module fdtw_name_scan
  import fdtw_pkg::*;
(
  input  logic [31:0]           word,
  input  logic [POS_BITS-1:0]   position,
  input  logic                  equal,
  input  logic [NAME_BITS-1:0]  tgt_name,
  input  logic [TLEN_BITS-1:0]  tgt_len,
  output name_scan_t            scan
);

  always_comb begin
    logic [7:0]          c;
    logic [POS_BITS-1:0] p;
    logic                eq;
    logic                ended;
    p     = position;
    eq    = equal;
    ended = 1'b0;
    for (int b = 0; b < 4; b++) begin
      c = word[31 - 8 * b -: 8];
      if (!ended) begin
        if (c == CHAR_NUL) begin
          ended = 1'b1;
        end else begin
          if (tgt_len != '0) begin
            if (TLEN_BITS'(p) < tgt_len) begin
              if (c != target_char(tgt_name, p[CHAR_SEL_BITS-1:0])) eq = 1'b0;
            end else if (TLEN_BITS'(p) == tgt_len) begin
              if (c != CHAR_AT) eq = 1'b0;
            end
          end
          p = (p != POS_MAX) ? p + 1'b1 : POS_MAX;
        end
      end
    end
    scan.ended    = ended;
    scan.position = p;
    scan.equal    = eq;
  end

endmodule

// ----- src/fdtw_core.sv -----
// Token decoder and walk state: one structure word per beat, at most one event out.
module fdtw_core
  import fdtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        take,
  input  logic [31:0] word,
  input  logic        first,
  output logic        ev_valid,
  output event_t      ev
);

  typedef enum logic [2:0] {PH_TOKEN, PH_NAME, PH_LEN, PH_OFF, PH_SKIP} phase_t;

  logic [NAME_BITS-1:0]  tgt_name;
  logic [TLEN_BITS-1:0]  target_length;
  logic [TLEN_BITS-1:0]  tlen;

  phase_t                phase, phase_next, c_phase;
  logic [DEPTH_BITS-1:0] depth_count, depth_next, c_depth;
  logic [INDEX_BITS-1:0] word_index, index_next, c_index;
  logic [INDEX_BITS-1:0] token_start, tstart_next, c_tstart;
  logic [SKIP_BITS-1:0]  words_to_skip, skip_next, c_skip;
  logic [31:0]           held_length, length_next, c_length;
  logic [31:0]           held_offset, offset_next, c_offset;
  logic [POS_BITS-1:0]   name_position, pos_next, c_pos;
  logic                  name_equal, equal_next, c_equal;
  logic                  finished, finished_next, c_finished;
  logic [32:0]           len_round;
  logic                  emit;
  event_t                ev_next;
  name_scan_t            scan;

  assign tlen = (target_length > TLEN_MAX) ? TLEN_MAX : target_length;

  // A first-marked word starts from the cleared walk state
  always_comb begin
    c_phase    = first ? PH_TOKEN  : phase;
    c_depth    = first ? '0        : depth_count;
    c_index    = first ? '0        : word_index;
    c_tstart   = first ? '0        : token_start;
    c_skip     = first ? '0        : words_to_skip;
    c_length   = first ? '0        : held_length;
    c_offset   = first ? '0        : held_offset;
    c_pos      = first ? '0        : name_position;
    c_equal    = first ? 1'b1      : name_equal;
    c_finished = first ? 1'b0      : finished;
  end

  fdtw_name_scan u_name_scan (
    .word     (word),
    .position (c_pos),
    .equal    (c_equal),
    .tgt_name (tgt_name),
    .tgt_len  (tlen),
    .scan     (scan)
  );

  assign len_round = {1'b0, c_length} + 33'd3;

  always_comb begin
    phase_next    = c_phase;
    depth_next    = c_depth;
    index_next    = (c_index != INDEX_MAX) ? c_index + 1'b1 : INDEX_MAX;
    tstart_next   = c_tstart;
    skip_next     = c_skip;
    length_next   = c_length;
    offset_next   = c_offset;
    pos_next      = c_pos;
    equal_next    = c_equal;
    finished_next = c_finished;
    emit          = 1'b0;
    ev_next       = '0;

    if (!c_finished) begin
      unique case (c_phase)
        PH_TOKEN: begin
          tstart_next = c_index;
          if (word == TOK_BEGIN_NODE) begin
            pos_next   = '0;
            equal_next = 1'b1;
            phase_next = PH_NAME;
          end else if (word == TOK_END_NODE) begin
            if (c_depth != '0) depth_next = c_depth - 1'b1;
            finished_next      = (depth_next == '0);
            emit               = 1'b1;
            ev_next.event_kind = EV_END_NODE;
            ev_next.walk_done  = (depth_next == '0);
          end else if (word == TOK_PROP) begin
            phase_next = PH_LEN;
          end else if (word == TOK_END) begin
            finished_next      = 1'b1;
            emit               = 1'b1;
            ev_next.event_kind = EV_END;
            ev_next.walk_done  = 1'b1;
          end
        end
        PH_NAME: begin
          pos_next   = scan.position;
          equal_next = scan.equal;
          if (scan.ended) begin
            if (c_depth != DEPTH_MAX) depth_next = c_depth + 1'b1;
            phase_next         = PH_TOKEN;
            emit               = 1'b1;
            ev_next.event_kind = EV_BEGIN_NODE;
            if (tlen == '0)
              ev_next.matched = (depth_next == DEPTH_BITS'(1)) && (scan.position == '0);
            else
              ev_next.matched = (depth_next == DEPTH_BITS'(2)) && scan.equal &&
                                (TLEN_BITS'(scan.position) >= tlen);
          end
        end
        PH_LEN: begin
          length_next = word;
          phase_next  = PH_OFF;
        end
        PH_OFF: begin
          offset_next           = word;
          skip_next             = len_round[32:2];
          phase_next            = (len_round[32:2] != '0) ? PH_SKIP : PH_TOKEN;
          emit                  = 1'b1;
          ev_next.event_kind    = EV_PROP;
          ev_next.value_length  = c_length;
          ev_next.string_offset = word;
        end
        PH_SKIP: begin
          if (c_skip != '0) skip_next = c_skip - 1'b1;
          if (skip_next == '0) phase_next = PH_TOKEN;
        end
        default: phase_next = PH_TOKEN;
      endcase
    end
    ev_next.tok_index     = tstart_next;
    ev_next.nesting_depth = depth_next;
  end

  assign ev_valid = take & emit;
  assign ev       = ev_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_name      <= '0;
      target_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_NAME:   tgt_name      <= cfg_data[NAME_BITS-1:0];
        CFG_TARGET_LENGTH: target_length <= cfg_data[TLEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TOKEN;
      depth_count   <= '0;
      word_index    <= '0;
      token_start   <= '0;
      words_to_skip <= '0;
      held_length   <= '0;
      held_offset   <= '0;
      name_position <= '0;
      name_equal    <= 1'b1;
      finished      <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      depth_count   <= depth_next;
      word_index    <= index_next;
      token_start   <= tstart_next;
      words_to_skip <= skip_next;
      held_length   <= length_next;
      held_offset   <= offset_next;
      name_position <= pos_next;
      name_equal    <= equal_next;
      finished      <= finished_next;
    end
  end

endmodule

// ----- src/fdtw_out_buf.sv -----
// Two-entry event buffer: output register plus skid entry.
module fdtw_out_buf
  import fdtw_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t push_data,
  output logic   ready,
  output logic   out_valid,
  output event_t out_data,
  input  logic   out_ready
);

  logic   skid_valid;
  event_t skid_data;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      // Drain the skid entry first; a push only arrives with the skid empty
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- src/fdt_structure_walker.sv -----
// Flattened device-tree structure walker: one structure word per beat in, token events out.
//
// Feed the structure block one big-endian 32-bit word per slave beat, with
// s_tuser set on the first word of a walk to clear depth, word index and
// phase. The walker decodes BEGIN_NODE, END_NODE, PROP, NOP and END, skips
// node names up to their zero byte plus padding, skips property values, and
// issues one event per BEGIN_NODE, END_NODE, PROP and END token. A begin-node
// event carries matched when its name at depth 2 equals the target (followed
// by NUL or '@'), or, with a zero target length, when it is the empty-named
// root at depth 1. Unknown tokens count as NOP. After END, or an END_NODE that
// leaves the depth at zero, words are absorbed silently until the next first
// word. Rate: one word per clock while s_tready is high; the word beat that
// completes an event registers it into the output buffer. The whole decode
// for a word is a single register-to-register step, and a two-entry output
// buffer lets a word be taken while an earlier event waits. s_tready drops
// only while the skid entry is occupied, which happens when a word completes
// an event while the master side holds off an earlier one; it rises again the
// cycle after the master side takes a beat. Write the target registers only
// while no walk is in flight.
module fdt_structure_walker
  import fdtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  // Structure words in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] word
  input  logic        s_tuser,   // [0] first
  // Token events out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [23:0] tok_index, [31:24] nesting_depth,
                                 // [63:32] value_length, [95:64] string_offset
  output logic [2:0]  m_tuser,   // [1:0] event_kind, [2] matched
  output logic        m_tlast    // walk_done
);

  logic   take;
  logic   ev_valid;
  event_t ev;
  event_t out_ev;

  // Take a word whenever one is offered and the skid entry is free
  assign take = s_tvalid & s_tready;

  fdtw_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .word      (s_tdata),
    .first     (s_tuser),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  fdtw_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_valid),
    .push_data (ev),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_data  (out_ev),
    .out_ready (m_tready)
  );

  // Pack the event beat
  assign m_tdata = {out_ev.string_offset, out_ev.value_length,
                    out_ev.nesting_depth, out_ev.tok_index};
  assign m_tuser = {out_ev.matched, out_ev.event_kind};
  assign m_tlast = out_ev.walk_done;

endmodule

// ----- src/fdtw_checker.sv -----
// Port-level assertions for the structure walker, bound to the top level.
module fdtw_checker
  import fdtw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // Hold a stalled event beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled event beat changed");

  a_match_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1:0] == EV_BEGIN_NODE)
    else $error("match flag on a non begin-node event");

  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tuser[1:0] == EV_END_NODE || m_tuser[1:0] == EV_END))
    else $error("walk done on wrong event kind");

  a_end_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == EV_END |-> m_tlast)
    else $error("end event without walk done");

  a_prop_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != EV_PROP |-> m_tdata[95:32] == '0)
    else $error("length or offset set on a non-property event");

endmodule

bind fdt_structure_walker fdtw_checker u_fdtw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- dv/tb_fdt_structure_walker.sv -----
// Self-checking testbench for the device-tree structure walker.
`timescale 1ns / 1ps

module tb_fdt_structure_walker;
  import fdtw_pkg::*;

  // NOP has no constant of its own in the package; unknown tokens behave alike
  localparam logic [31:0] NOP_TOKEN   = 32'd4;
  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_BEATS  = 80;

  typedef enum logic [2:0] {
    SEEK_TOKEN,
    IN_NAME,
    AT_LENGTH,
    AT_OFFSET,
    IN_VALUE
  } walk_phase_t;

  // One row of the opening sequence. Pinned rows carry a hand-typed outcome
  // (yields says whether an event is due at all); the rest use the predictor.
  typedef struct packed {
    logic [31:0] word;
    logic        first;
    logic        pinned;
    logic        yields;
    event_t      ev;
  } opening_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  fdt_structure_walker u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Predictor copy of the target registers
  logic [63:0]           w_tgt_name;
  logic [3:0]            w_tgt_len;
  // Predictor copy of the walk state
  walk_phase_t           w_phase;
  logic [DEPTH_BITS-1:0] w_depth;
  logic [INDEX_BITS-1:0] w_index;
  logic [INDEX_BITS-1:0] w_tok_start;
  logic [30:0]           w_skip;
  logic [31:0]           w_held_len;
  logic [31:0]           w_held_off;
  logic [3:0]            w_name_pos;
  logic                  w_name_eq;
  logic                  w_done;

  event_t events_due[$];
  int     mismatches  = 0;
  int     live_beats  = 0;
  int     quiet       = 0;
  bit     calm        = 0;
  int     hold_asked  = 0;
  int     hold_given  = 0;
  int     hold_left   = 0;

  // Opening sequence, walked with the reset target (empty name, root match).
  // Word indexes in the comments count from the first word of each walk.
  opening_row_t opening [25] = '{
    // 0: begin the root
    '{TOK_BEGIN_NODE, 1'b1, 1'b1, 1'b0, '0},
    // 1: empty root name, matched at depth 1
    '{32'h0000_0000, 1'b0, 1'b1, 1'b1,
      '{EV_BEGIN_NODE, 24'd0, 8'd1, 32'd0, 32'd0, 1'b1, 1'b0}},
    // 2..4: property with zero length and the largest name offset
    '{TOK_PROP, 1'b0, 1'b1, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b1, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1,
      '{EV_PROP, 24'd2, 8'd1, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0}},
    // 5..9: five-byte property, two value words, the second one looking like END
    '{TOK_PROP, 1'b0, 1'b0, 1'b0, '0},
    '{32'd5, 1'b0, 1'b0, 1'b0, '0},
    '{32'h1234_5678, 1'b0, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
    '{TOK_END, 1'b0, 1'b0, 1'b0, '0},
    // 10, 11: NOP and an unknown token, both silent
    '{NOP_TOKEN, 1'b0, 1'b1, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b1, 1'b0, '0},
    // 12..14: "cpus@0" at depth 2
    '{TOK_BEGIN_NODE, 1'b0, 1'b0, 1'b0, '0},
    '{32'h6370_7573, 1'b0, 1'b0, 1'b0, '0},
    '{32'h4030_0000, 1'b0, 1'b0, 1'b0, '0},
    // 15, 16: "A" at depth 3
    '{TOK_BEGIN_NODE, 1'b0, 1'b0, 1'b0, '0},
    '{32'h4100_0000, 1'b0, 1'b0, 1'b0, '0},
    // 17..19: close back to zero; the last close ends the walk
    '{TOK_END_NODE, 1'b0, 1'b0, 1'b0, '0},
    '{TOK_END_NODE, 1'b0, 1'b0, 1'b0, '0},
    '{TOK_END_NODE, 1'b0, 1'b1, 1'b1,
      '{EV_END_NODE, 24'd19, 8'd0, 32'd0, 32'd0, 1'b0, 1'b1}},
    // 20: walk over, a token is swallowed
    '{TOK_BEGIN_NODE, 1'b0, 1'b1, 1'b0, '0},
    // 21: fresh walk that is only END
    '{TOK_END, 1'b1, 1'b1, 1'b1,
      '{EV_END, 24'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b1}},
    // 22: fresh walk, END_NODE at depth zero holds the depth at zero
    '{TOK_END_NODE, 1'b1, 1'b1, 1'b1,
      '{EV_END_NODE, 24'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b1}},
    // 23, 24: root with a non-empty name, left open
    '{TOK_BEGIN_NODE, 1'b1, 1'b0, 1'b0, '0},
    '{32'h2F00_0000, 1'b0, 1'b0, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_walk();
    w_phase     = SEEK_TOKEN;
    w_depth     = '0;
    w_index     = '0;
    w_tok_start = '0;
    w_skip      = '0;
    w_held_len  = '0;
    w_held_off  = '0;
    w_name_pos  = '0;
    w_name_eq   = 1'b1;
    w_done      = 1'b0;
  endfunction

  function automatic event_t make_event(input logic [1:0] kind, input logic [31:0] len,
                                        input logic [31:0] off, input logic hit,
                                        input logic fin);
    event_t ev;
    ev.event_kind    = kind;
    ev.tok_index     = w_tok_start;
    ev.nesting_depth = w_depth;
    ev.value_length  = len;
    ev.string_offset = off;
    ev.matched       = hit;
    ev.walk_done     = fin;
    return ev;
  endfunction

  // Advance the walk by one structure word; return 1 when it closes an event.
  function automatic bit decode_word(input logic [31:0] word, input logic first,
                                     output event_t ev);
    logic [INDEX_BITS-1:0] cur;
    logic [3:0]            tl;
    logic [7:0]            c;
    bit                    ended;
    bit                    hit;
    bit                    got;
    ev  = '0;
    got = 1'b0;
    tl  = (w_tgt_len > 4'(MAX_NAME_CHARS)) ? 4'(MAX_NAME_CHARS) : w_tgt_len;
    if (first)
      clear_walk();
    cur = w_index;
    if (w_index != INDEX_MAX)
      w_index = w_index + 1'b1;
    if (w_done)
      return 1'b0;

    case (w_phase)
      SEEK_TOKEN: begin
        w_tok_start = cur;
        if (word == TOK_BEGIN_NODE) begin
          w_name_pos = '0;
          w_name_eq  = 1'b1;
          w_phase    = IN_NAME;
        end else if (word == TOK_END_NODE) begin
          if (w_depth != 0)
            w_depth = w_depth - 1'b1;
          if (w_depth == 0)
            w_done = 1'b1;
          ev  = make_event(EV_END_NODE, '0, '0, 1'b0, w_depth == 0);
          got = 1'b1;
        end else if (word == TOK_PROP) begin
          w_phase = AT_LENGTH;
        end else if (word == TOK_END) begin
          w_done = 1'b1;
          ev     = make_event(EV_END, '0, '0, 1'b0, 1'b1);
          got    = 1'b1;
        end
      end
      IN_NAME: begin
        ended = 1'b0;
        for (int b = 0; b < 4; b++) begin
          c = word[31 - 8 * b -: 8];
          if (!ended) begin
            if (c == CHAR_NUL) begin
              ended = 1'b1;
            end else begin
              // past the target the next character must be '@'; beyond that, anything
              if (tl != 0) begin
                if (w_name_pos < tl) begin
                  if (c != w_tgt_name[63 - 8 * w_name_pos[2:0] -: 8])
                    w_name_eq = 1'b0;
                end else if (w_name_pos == tl) begin
                  if (c != CHAR_AT)
                    w_name_eq = 1'b0;
                end
              end
              if (w_name_pos != POS_MAX)
                w_name_pos = w_name_pos + 1'b1;
            end
          end
        end
        if (ended) begin
          if (w_depth != DEPTH_MAX)
            w_depth = w_depth + 1'b1;
          if (tl == 0)
            hit = (w_depth == 1) && (w_name_pos == 0);
          else
            hit = (w_depth == 2) && w_name_eq && (w_name_pos >= tl);
          w_phase = SEEK_TOKEN;
          ev      = make_event(EV_BEGIN_NODE, '0, '0, hit, 1'b0);
          got     = 1'b1;
        end
      end
      AT_LENGTH: begin
        w_held_len = word;
        w_phase    = AT_OFFSET;
      end
      AT_OFFSET: begin
        w_held_off = word;
        w_skip     = 31'(({1'b0, w_held_len} + 33'd3) >> 2);
        w_phase    = (w_skip != 0) ? IN_VALUE : SEEK_TOKEN;
        ev         = make_event(EV_PROP, w_held_len, w_held_off, 1'b0, 1'b0);
        got        = 1'b1;
      end
      IN_VALUE: begin
        if (w_skip != 0)
          w_skip = w_skip - 1'b1;
        if (w_skip == 0)
          w_phase = SEEK_TOKEN;
      end
      default: w_phase = SEEK_TOKEN;
    endcase
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Compare every event beat with the oldest expectation, field by field
  always @(posedge clk) begin
    event_t seen;
    event_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.tok_index     = m_tdata[23:0];
      seen.nesting_depth = m_tdata[31:24];
      seen.value_length  = m_tdata[63:32];
      seen.string_offset = m_tdata[95:64];
      seen.event_kind    = m_tuser[1:0];
      seen.matched       = m_tuser[2];
      seen.walk_done     = m_tlast;
      if (events_due.size() == 0) begin
        report("event with none due, kind", 32'(seen.event_kind), 32'd0);
      end else begin
        want = events_due.pop_front();
        if (seen.event_kind != want.event_kind)
          report("event_kind", 32'(seen.event_kind), 32'(want.event_kind));
        if (seen.tok_index != want.tok_index)
          report("token index", 32'(seen.tok_index), 32'(want.tok_index));
        if (seen.nesting_depth != want.nesting_depth)
          report("nesting_depth", 32'(seen.nesting_depth), 32'(want.nesting_depth));
        if (seen.value_length != want.value_length)
          report("value_length", seen.value_length, want.value_length);
        if (seen.string_offset != want.string_offset)
          report("string_offset", seen.string_offset, want.string_offset);
        if (seen.matched != want.matched)
          report("matched", 32'(seen.matched), 32'(want.matched));
        if (seen.walk_done != want.walk_done)
          report("walk_done", 32'(seen.walk_done), 32'(want.walk_done));
      end
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Event receiver: random back-pressure, none while calm, and a long hold-off
  // on request so the walker fills its buffer and stalls the word side.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_given) begin
        hold_given = hold_asked;
        hold_left  = HOLD_BEATS;
      end
      if (hold_left > 0) begin
        m_tready  <= 1'b0;
        hold_left  = hold_left - 1;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until taken; called and returning at a falling
  // edge. The caller either offers again or drops s_tvalid in that same step.
  task automatic offer(input logic [31:0] word, input logic first, input logic pinned,
                       input logic yields, input event_t pin_ev);
    event_t ev;
    bit     got;
    bit     live;
    if (!calm) begin
      while ($urandom_range(0, 99) < 11) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    // words after the walk has ended are absorbed and do not count
    live = first || !w_done;
    got  = decode_word(word, first, ev);
    if (pinned) begin
      if (yields)
        events_due.push_back(pin_ev);
    end else if (got) begin
      events_due.push_back(ev);
    end
    if (live)
      live_beats++;
    @(negedge clk);
  endtask

  task automatic put(input logic [31:0] word, input logic first);
    offer(word, first, 1'b0, 1'b0, '0);
  endtask

  function automatic logic [31:0] noise_word();
    return ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 15));
  endfunction

  // Drop the word side, wait for every due event, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (events_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_target(input logic [63:0] name, input logic [63:0] len_data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_NAME;
    cfg_data  <= name;
    @(negedge clk);
    cfg_index <= CFG_TARGET_LENGTH;
    cfg_data  <= len_data;
    @(negedge clk);
    cfg_we     <= 1'b0;
    w_tgt_name  = name;
    w_tgt_len   = len_data[3:0];
  endtask

  // Node name words: mostly near-misses and hits of the current target
  task automatic put_name();
    logic [7:0]  chars[$];
    logic [31:0] w;
    int          tl;
    int          mode;
    int          n;
    tl   = (w_tgt_len > 4'(MAX_NAME_CHARS)) ? MAX_NAME_CHARS : int'(w_tgt_len);
    mode = $urandom_range(0, 5);
    case (mode)
      0, 1, 2, 4: begin
        for (int k = 0; k < tl; k++)
          chars.push_back(w_tgt_name[63 - 8 * k -: 8]);
        if (mode == 1) begin
          chars.push_back(CHAR_AT);
          repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(1, 255)));
        end else if (mode == 2) begin
          chars.push_back(8'($urandom_range(1, 255)));
        end else if (mode == 4 && tl > 0) begin
          n        = $urandom_range(0, tl - 1);
          chars[n] = chars[n] ^ 8'($urandom_range(1, 255));
        end
      end
      3: begin
        n = (tl > 0) ? $urandom_range(0, tl - 1) : 0;
        for (int k = 0; k < n; k++)
          chars.push_back(w_tgt_name[63 - 8 * k -: 8]);
      end
      default: begin
        // long enough to run the name position into its ceiling
        repeat ($urandom_range(0, 20)) chars.push_back(8'($urandom_range(1, 255)));
      end
    endcase
    chars.push_back(CHAR_NUL);
    // the rest of the word after the zero byte is padding of any value
    while (chars.size() % 4 != 0)
      chars.push_back(8'($urandom));
    for (int k = 0; k < chars.size(); k += 4) begin
      w = {chars[k], chars[k + 1], chars[k + 2], chars[k + 3]};
      put(w, 1'b0);
    end
  endtask

  // Property: token, length, name offset and value words. A huge length is
  // only used to close a walk, since its value would take ages to skip.
  task automatic put_prop(input bit huge);
    logic [31:0] len;
    if (huge)
      len = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
    else
      len = ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom_range(1, 13));
    put(TOK_PROP, 1'b0);
    put(len, 1'b0);
    put($urandom, 1'b0);
    if (!huge)
      repeat ((len + 3) / 4) put(noise_word(), 1'b0);
  endtask

  // One walk: mostly a well-formed tree with random content, sometimes cut
  // short, closed by END at depth, or replaced by a burst of noise.
  task automatic gen_walk();
    int d;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      repeat ($urandom_range(4, 12)) put(noise_word(), 1'($urandom_range(0, 1)));
      return;
    end
    put(TOK_BEGIN_NODE, 1'b1);
    if ($urandom_range(0, 99) < 85)
      put({8'h00, 24'($urandom)}, 1'b0);
    else
      put_name();
    d = 1;
    repeat ($urandom_range(3, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 30 && d < 5) begin
        put(TOK_BEGIN_NODE, 1'b0);
        put_name();
        d++;
      end else if (r < 48 && d > 1) begin
        put(TOK_END_NODE, 1'b0);
        d--;
      end else if (r < 84) begin
        put_prop(1'b0);
      end else if (r < 92) begin
        put(NOP_TOKEN, 1'b0);
      end else begin
        put(noise_word(), 1'b0);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      put_prop(1'b1);
    end else if (r < 16) begin
      // truncated: the next walk's first word clears the state
    end else if (r < 30) begin
      put(TOK_END, 1'b0);
    end else begin
      repeat (d) put(TOK_END_NODE, 1'b0);
      if ($urandom_range(0, 1) != 0)
        put(TOK_END, 1'b0);
    end
    repeat ($urandom_range(0, 2)) put($urandom, 1'b0);
  endtask

  task automatic walk_phase(input logic [63:0] name, input logic [3:0] len,
                            input bit squeeze, input int beats);
    int start;
    // random upper bits on the length write must be ignored
    write_target(name, ({$urandom, $urandom} & ~64'hF) | 64'(len));
    if (squeeze)
      hold_asked++;
    start = live_beats;
    while (live_beats - start < beats)
      gen_walk();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [63:0] nm;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_TARGET_NAME;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    w_tgt_name = '0;
    w_tgt_len  = '0;
    clear_walk();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Opening table with the reset target
    foreach (opening[i])
      offer(opening[i].word, opening[i].first, opening[i].pinned, opening[i].yields,
            opening[i].ev);

    // A short real name, with no idling on either side
    calm = 1;
    walk_phase({"cpus", 32'h0}, 4'd4, 1'b0, 40);
    calm = 0;

    // All-ones name at full length, with the receiver held off at the start
    walk_phase('1, 4'd8, 1'b1, 20);

    // Length beyond the name width counts as full width
    for (int k = 0; k < 8; k++)
      nm[8 * k +: 8] = 8'($urandom_range(1, 255));
    walk_phase(nm, 4'd15, 1'b0, 20);

    // Root target, then one walk deep enough to pin the depth at its ceiling
    walk_phase('0, 4'd0, 1'b0, 15);
    put(TOK_BEGIN_NODE, 1'b1);
    put(32'h0, 1'b0);
    repeat (259) begin
      put(TOK_BEGIN_NODE, 1'b0);
      put($urandom & 32'h00FF_FFFF, 1'b0);
    end
    repeat (3) put(TOK_END_NODE, 1'b0);

    for (int k = 0; k < 8; k++)
      nm[8 * k +: 8] = 8'($urandom_range(1, 255));
    walk_phase(nm, 4'($urandom_range(1, 7)), 1'b0, 20);

    // Any name bits at all, any length
    walk_phase({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0, 20);

    settle();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
